### design/assert_macros.svh
// Assertion macros used by the per-class queue back end.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PCQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define PCQ_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### design/pcq_pkg.sv
// Package for the per-class bounded queue bank: sizes, codes and the
// command struct passed from front to back. No dependencies.
`default_nettype none

package pcq_pkg;

   localparam int NUM_QUEUES   = 32;
   localparam int QUEUE_DEPTH  = 8;
   localparam int TAG_WIDTH    = 16;
   localparam int LIMIT_RESET  = 5;

   // Fixed field widths of the ports
   localparam int QIDX_PORT_W  = 5;
   localparam int LIMIT_W      = 4;
   localparam int COUNT_PORT_W = 4;

   // Derived widths
   localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = QW + PTR_W;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_TAKE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ADDED = 2'd0,
      ST_FULL  = 2'd1,
      ST_TAKEN = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Classified request as held between front and back
   typedef struct packed {
      op_type               op;
      logic                 q_ok;
      logic [QW-1:0]        qidx;
      logic [TAG_WIDTH-1:0] tag;
      logic                 urgent;
   } cmd_type;

endpackage

`default_nettype wire

### design/pcq_front.sv
// Front end: accepts requests, classifies them and holds them in a
// two-entry queue for the back end. Depends on pcq_pkg.
`default_nettype none

module pcq_front
   import pcq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic                   req_func,
   input  wire logic [QIDX_PORT_W-1:0] req_queue_index,
   input  wire logic [TAG_WIDTH-1:0]   req_entry_tag,
   input  wire logic                   req_urgent,
   output logic                        cmd_valid,
   output cmd_type                     cmd,
   input  wire logic                   cmd_take
);

   localparam int FDEPTH = 2;
   localparam int FPTR_W = 1;
   localparam int FCNT_W = 2;
   localparam int QCMP_W = QIDX_PORT_W + 1;

   cmd_type              entry_ff [FDEPTH];
   logic [FPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0]    count_ff, count_in;
   logic                 push_xfer;
   cmd_type              cls;

   // Classify the incoming request
   always_comb begin
      cls.op     = op_type'(req_func);
      cls.q_ok   = {1'b0, req_queue_index} < QCMP_W'(NUM_QUEUES);
      cls.qidx   = req_queue_index[QW-1:0];
      cls.tag    = req_entry_tag;
      cls.urgent = req_urgent;
   end

   assign full      = (count_ff == FCNT_W'(FDEPTH));
   assign push_xfer = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push_xfer ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_take  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FCNT_W'(push_xfer) - FCNT_W'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

### design/pcq_back.sv
// Back end: per-queue head and count state, entry memory, the limit
// register and the result register. Depends on pcq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pcq_back
   import pcq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [LIMIT_W-1:0]      csr_write_data,
   input  wire logic                    cmd_valid,
   input  cmd_type                      cmd,
   output logic                         cmd_take,
   output logic                         empty,
   input  wire logic                    pop,
   output logic [1:0]                   rsp_status,
   output logic [TAG_WIDTH-1:0]         rsp_taken_tag,
   output logic                         rsp_taken_urgent,
   output logic [COUNT_PORT_W-1:0]      rsp_count_after
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

   state_type               state_ff, state_in;
   logic [LIMIT_W-1:0]      limit_ff;
   logic [CNT_W-1:0]        count_ff [NUM_QUEUES];
   logic [PTR_W-1:0]        head_ff  [NUM_QUEUES];
   logic [TAG_WIDTH:0]      mem [MEM_DEPTH];
   logic [TAG_WIDTH:0]      rd_data_ff;
   logic [CNT_W-1:0]        pend_cnt_ff, pend_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [TAG_WIDTH-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                    rsp_urg_ff, rsp_urg_in;
   logic [CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;

   logic                    out_free, start;
   logic [CNT_W-1:0]        cnt_rd, cnt_next, eff_lim;
   logic [PTR_W-1:0]        head_rd, head_next, head_m1, head_p1, slot;
   logic [PTR_W:0]          tail_sum;
   logic                    is_full, is_empty;
   logic                    upd, mem_wr, mem_rd;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic                    load_now;
   status_type              now_status;

   assign out_free = !rsp_valid_ff || pop;
   assign start    = cmd_valid && (state_ff == S_IDLE) && out_free;
   assign cmd_take = start;

   // Limit saturates at the queue depth
   assign eff_lim = (limit_ff > LIMIT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                       : CNT_W'(limit_ff);

   // Ring arithmetic on the addressed queue
   always_comb begin
      cnt_rd   = count_ff[cmd.qidx];
      head_rd  = head_ff[cmd.qidx];
      head_m1  = (head_rd == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_rd - 1'b1;
      head_p1  = (head_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_rd + 1'b1;
      tail_sum = {1'b0, head_rd} + (PTR_W+1)'(cnt_rd);
      slot     = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                 ? PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH)) : tail_sum[PTR_W-1:0];
      is_full  = !cmd.q_ok || (cnt_rd >= eff_lim);
      is_empty = !cmd.q_ok || (cnt_rd == '0);
   end

   // Execute one command
   always_comb begin
      upd        = 1'b0;
      mem_wr     = 1'b0;
      mem_rd     = 1'b0;
      head_next  = head_rd;
      cnt_next   = cnt_rd;
      now_status = ST_FULL;
      load_now   = 1'b0;
      wr_addr    = {cmd.qidx, slot};
      rd_addr    = {cmd.qidx, head_rd};
      case (cmd.op)
         OP_ADD: begin
            load_now = start;
            if (!is_full) begin
               upd        = start;
               mem_wr     = start;
               cnt_next   = cnt_rd + 1'b1;
               now_status = ST_ADDED;
               if (cmd.urgent) begin
                  head_next = head_m1;
                  wr_addr   = {cmd.qidx, head_m1};
               end
            end else begin
               now_status = ST_FULL;
            end
         end
         OP_TAKE: begin
            if (!is_empty) begin
               upd       = start;
               mem_rd    = start;
               head_next = head_p1;
               cnt_next  = cnt_rd - 1'b1;
            end else begin
               load_now   = start;
               now_status = ST_EMPTY;
            end
         end
         default: begin
            load_now = 1'b0;
         end
      endcase
   end

   // Sequencer and result register
   always_comb begin
      state_in      = state_ff;
      pend_cnt_in   = pend_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !pop;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_urg_in    = rsp_urg_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (mem_rd) begin
               state_in    = S_READ;
               pend_cnt_in = cnt_next;
            end else if (load_now) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = now_status;
               rsp_tag_in    = '0;
               rsp_urg_in    = 1'b0;
               rsp_cnt_in    = cmd.q_ok ? cnt_next : '0;
            end
         end
         S_READ: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_TAKEN;
            rsp_tag_in    = rd_data_ff[TAG_WIDTH:1];
            rsp_urg_in    = rd_data_ff[0];
            rsp_cnt_in    = pend_cnt_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_cnt_ff   <= pend_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_urg_ff    <= rsp_urg_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   // Per-queue head and count, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else if (upd) begin
         count_ff[cmd.qidx] <= cnt_next;
         head_ff[cmd.qidx]  <= head_next;
      end
   end

   // Entry memory: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= {cmd.tag, cmd.urgent};
      end
      if (mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_taken_tag    = rsp_tag_ff;
   assign rsp_taken_urgent = rsp_urg_ff;
   assign rsp_count_after  = COUNT_PORT_W'(rsp_cnt_ff);

   `PCQ_ASSERT(a_cnt_bound, clock, reset, upd |-> (cnt_next <= CNT_W'(QUEUE_DEPTH)), "queue count exceeds depth")
   `PCQ_NEVER(a_read_out_busy, clock, reset, (state_ff == S_READ) && rsp_valid_ff, "result register busy during read")
   `PCQ_ASSERT(a_take_to_read, clock, reset, mem_rd |=> (state_ff == S_READ) && empty, "take did not move to read")

endmodule

`default_nettype wire

### design/per_class_bounded_priority_queue_top.sv
// Top level of the per-class bounded queue bank: front end, back end.
// Depends on pcq_pkg, pcq_front and pcq_back.
`default_nettype none

// A bank of 32 bounded queues of up to 8 entries each. Push an add (entry at
// the tail, or at the head when urgent) or a take (pop the head); each request
// gives one result on the result queue side. An add, a rejected add and a take
// on an empty queue write the result register straight from the back end; a
// successful take goes through a read state first, since the entry memory read
// is registered. A two-entry request queue sits in front of the back end, and a
// result register behind it; while a result waits to be popped the back end
// stalls and up to two more requests are taken in before full rises.
// queue_limit (reset 5) is written through csr_write_enable / csr_write_data.
// The user must write it only while the block is idle; the block does not
// enforce this itself.
module per_class_bounded_priority_queue_top
   import pcq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   output logic                         full,
   input  wire logic                    req_func,
   input  wire logic [QIDX_PORT_W-1:0]  req_queue_index,
   input  wire logic [TAG_WIDTH-1:0]    req_entry_tag,
   input  wire logic                    req_urgent,
   output logic                         empty,
   input  wire logic                    pop,
   output logic [1:0]                   rsp_status,
   output logic [TAG_WIDTH-1:0]         rsp_taken_tag,
   output logic                         rsp_taken_urgent,
   output logic [COUNT_PORT_W-1:0]      rsp_count_after,
   input  wire logic                    csr_write_enable,
   input  wire logic [LIMIT_W-1:0]      csr_write_data
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   // Request acceptance and classification
   pcq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_func        (req_func),
      .req_queue_index (req_queue_index),
      .req_entry_tag   (req_entry_tag),
      .req_urgent      (req_urgent),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   // Queue state, entry memory and results
   pcq_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_status       (rsp_status),
      .rsp_taken_tag    (rsp_taken_tag),
      .rsp_taken_urgent (rsp_taken_urgent),
      .rsp_count_after  (rsp_count_after)
   );

endmodule

`default_nettype wire

### tb/sv/per_class_bounded_priority_queue_top_tb.sv
// Self-checking testbench for the per-class bounded queue bank top level.
// Depends on pcq_pkg and per_class_bounded_priority_queue_top; drives the
// request queue side, predicts every result and checks it on the result side.

module per_class_bounded_priority_queue_top_tb;
   import pcq_pkg::*;

   // One predicted result transfer
   typedef struct {
      status_type                status;
      logic [TAG_WIDTH-1:0]      tag;
      logic                      urg;
      logic [COUNT_PORT_W-1:0]   count;
   } queue_result_type;

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      full;
   logic                      req_func;
   logic [QIDX_PORT_W-1:0]    req_queue_index;
   logic [TAG_WIDTH-1:0]      req_entry_tag;
   logic                      req_urgent;
   logic                      empty;
   logic                      pop;
   logic [1:0]                rsp_status;
   logic [TAG_WIDTH-1:0]      rsp_taken_tag;
   logic                      rsp_taken_urgent;
   logic [COUNT_PORT_W-1:0]   rsp_count_after;
   logic                      csr_write_enable;
   logic [LIMIT_W-1:0]        csr_write_data;

   // Shadow copy of the queue bank
   logic [TAG_WIDTH-1:0]      shadow_tag   [NUM_QUEUES][QUEUE_DEPTH];
   logic                      shadow_urg   [NUM_QUEUES][QUEUE_DEPTH];
   logic [PTR_W-1:0]          shadow_head  [NUM_QUEUES];
   logic [COUNT_PORT_W-1:0]   shadow_count [NUM_QUEUES];
   logic [LIMIT_W-1:0]        shadow_limit;

   queue_result_type          pending_results [$];

   int                        tx_idle_pct;
   int                        rx_idle_pct;
   int                        hold_left;
   int                        mismatch_count;
   int                        items_sent;
   int                        results_checked;
   int                        status_tally [4];
   int                        limits_used;

   per_class_bounded_priority_queue_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_func         (req_func),
      .req_queue_index  (req_queue_index),
      .req_entry_tag    (req_entry_tag),
      .req_urgent       (req_urgent),
      .empty            (empty),
      .pop              (pop),
      .rsp_status       (rsp_status),
      .rsp_taken_tag    (rsp_taken_tag),
      .rsp_taken_urgent (rsp_taken_urgent),
      .rsp_count_after  (rsp_count_after),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock
   always #5 clock = ~clock;

   // Apply one operation to the shadow bank and return the result it gives
   function automatic queue_result_type predict_queue_op(op_type op,
                                                         logic [QIDX_PORT_W-1:0] qi,
                                                         logic [TAG_WIDTH-1:0] tag,
                                                         logic urg);
      queue_result_type        r;
      int unsigned             lim;
      logic [PTR_W-1:0]        hd;
      logic [PTR_W-1:0]        slot;
      logic [COUNT_PORT_W-1:0] cnt;
      r.tag   = '0;
      r.urg   = 1'b0;
      r.count = '0;
      lim = (shadow_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : shadow_limit;
      if (qi >= NUM_QUEUES) begin
         // Unknown class: nothing changes
         r.status = (op == OP_TAKE) ? ST_EMPTY : ST_FULL;
      end else begin
         hd  = shadow_head[qi];
         cnt = shadow_count[qi];
         if (op == OP_ADD) begin
            if (cnt >= lim) begin
               r.status = ST_FULL;
            end else begin
               // urgent goes in front of the head, regular behind the tail
               if (urg) begin
                  hd   = hd - 1'b1;
                  slot = hd;
               end else begin
                  slot = hd + cnt[PTR_W-1:0];
               end
               shadow_tag[qi][slot] = tag;
               shadow_urg[qi][slot] = urg;
               cnt = cnt + 1'b1;
               r.status = ST_ADDED;
            end
         end else begin
            if (cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.tag = shadow_tag[qi][hd];
               r.urg = shadow_urg[qi][hd];
               hd  = hd + 1'b1;
               cnt = cnt - 1'b1;
               r.status = ST_TAKEN;
            end
         end
         shadow_head[qi]  = hd;
         shadow_count[qi] = cnt;
         r.count = cnt;
      end
      return r;
   endfunction

   // Offer one request; returns once the transfer has happened
   task automatic send_op(op_type op, logic [QIDX_PORT_W-1:0] qi,
                          logic [TAG_WIDTH-1:0] tag, logic urg);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push            = 1'b1;
      req_func        = op;
      req_queue_index = qi;
      req_entry_tag   = tag;
      req_urgent      = urg;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_results.push_back(predict_queue_op(op, qi, tag, urg));
      items_sent++;
   endtask

   // Stop offering and wait until every predicted result has been popped
   task automatic drain_results();
      @(negedge clock);
      push = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write queue_limit with the block idle
   task automatic set_queue_limit(logic [LIMIT_W-1:0] value);
      drain_results();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      shadow_limit = value;
      limits_used++;
   endtask

   // Every operation and the head/tail ordering at the reset limit
   task automatic test_basic_ops();
      send_op(OP_TAKE, 5'd31, 16'hFFFF, 1'b1);   // take on empty queue
      send_op(OP_ADD,  5'd0,  16'h0000, 1'b0);
      send_op(OP_ADD,  5'd0,  16'hFFFF, 1'b0);
      send_op(OP_ADD,  5'd0,  16'h1234, 1'b1);   // urgent wraps head below 0
      send_op(OP_ADD,  5'd0,  16'hA5A5, 1'b1);   // ahead of earlier urgent
      send_op(OP_ADD,  5'd0,  16'h5A5A, 1'b0);
      send_op(OP_ADD,  5'd0,  16'hBEEF, 1'b0);   // rejected, at limit
      repeat (5) send_op(OP_TAKE, 5'd0, 16'h0000, 1'b0);
      send_op(OP_TAKE, 5'd0,  16'h0000, 1'b0);   // empty again
      send_op(OP_ADD,  5'd31, 16'hFFFF, 1'b1);
      send_op(OP_TAKE, 5'd31, 16'h0000, 1'b0);
   endtask

   // Zero limit rejects everything; oversized limit saturates at the depth
   task automatic test_limit_extremes();
      int i;
      set_queue_limit(4'd0);
      send_op(OP_ADD,  5'd7, 16'h00FF, 1'b0);
      send_op(OP_TAKE, 5'd7, 16'h0000, 1'b0);
      set_queue_limit(4'd15);
      for (i = 0; i < QUEUE_DEPTH + 1; i++)
         send_op(OP_ADD, 5'd9, 16'($urandom), i[0]);
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_full_stall();
      int i;
      set_queue_limit(4'd1);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_left = 300;
      for (i = 0; i < 40; i++)
         send_op(op_type'($urandom_range(1)), 5'($urandom_range(3)),
                 16'($urandom), 1'($urandom));
   endtask

   // Random traffic, mostly on a few hot classes so queues fill and wrap
   task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct,
                                      logic [LIMIT_W-1:0] limit_value);
      int i;
      int base;
      set_queue_limit(limit_value);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      base = $urandom_range(NUM_QUEUES - 4);
      for (i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 85)
            send_op(($urandom_range(99) < 55) ? OP_ADD : OP_TAKE,
                    5'(base + $urandom_range(3)), 16'($urandom),
                    ($urandom_range(2) == 0));
         else
            send_op(op_type'($urandom_range(1)), 5'($urandom_range(31)),
                    16'($urandom), 1'($urandom));
      end
   endtask

   // Receiver: random pops, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (reset) begin
         pop = 1'b0;
      end else if (hold_left > 0) begin
         pop = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         pop = ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Result checker: each transfer against the oldest prediction
   always @(posedge clock) begin
      queue_result_type exp_r;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result at %0t: status %0d tag %h urgent %b count %0d",
                        $time, rsp_status, rsp_taken_tag, rsp_taken_urgent,
                        rsp_count_after);
         end else begin
            exp_r = pending_results.pop_front();
            results_checked++;
            status_tally[exp_r.status]++;
            if (rsp_status !== exp_r.status || rsp_taken_tag !== exp_r.tag ||
                rsp_taken_urgent !== exp_r.urg || rsp_count_after !== exp_r.count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: expected %0d/%h/%b/%0d got %0d/%h/%b/%0d",
                           $time, exp_r.status, exp_r.tag, exp_r.urg, exp_r.count,
                           rsp_status, rsp_taken_tag, rsp_taken_urgent,
                           rsp_count_after);
            end
         end
      end
   end

   // Run limit
   initial begin
      #5000000;
      $display("per_class_bounded_priority_queue_top regression: fail");
      $finish;
   end

   // Test sequence
   initial begin
      int q;
      int s;
      clock            = 1'b0;
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_func         = 1'b0;
      req_queue_index  = '0;
      req_entry_tag    = '0;
      req_urgent       = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      tx_idle_pct      = 0;
      rx_idle_pct      = 0;
      hold_left        = 0;
      mismatch_count   = 0;
      items_sent       = 0;
      results_checked  = 0;
      limits_used      = 0;
      for (s = 0; s < 4; s++) status_tally[s] = 0;
      for (q = 0; q < NUM_QUEUES; q++) begin
         shadow_head[q]  = '0;
         shadow_count[q] = '0;
      end
      shadow_limit = LIMIT_W'(LIMIT_RESET);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_limit_extremes();
      test_full_stall();
      test_random_traffic(300, 7, 88, 4'd8);
      test_random_traffic(300, 88, 7, 4'd2);
      test_random_traffic(300, 0, 0, 4'($urandom_range(1, 8)));

      drain_results();
      repeat (20) @(posedge clock);
      $display("%0d requests, %0d results checked under %0d limit settings",
               items_sent, results_checked, limits_used);
      $display("added %0d, rejected %0d, taken %0d, empty %0d",
               status_tally[ST_ADDED], status_tally[ST_FULL],
               status_tally[ST_TAKEN], status_tally[ST_EMPTY]);
      if (mismatch_count == 0)
         $display("per_class_bounded_priority_queue_top regression: pass");
      else
         $display("per_class_bounded_priority_queue_top regression: fail");
      $finish;
   end

endmodule
